[sv/frame_sum_check_macros.svh]
// Assertion macros shared by the frame checker RTL.
// Included by the modules that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef FRAME_SUM_CHECK_MACROS_SVH
`define FRAME_SUM_CHECK_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/fsc_pkg.sv]
// Types, codes and helper functions of the frame sum checker.
// No dependencies; imported by every module of the block.
`default_nettype none

package fsc_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_BYTE = 2'd0;
    localparam logic [1:0] CFG_STOP_BYTE  = 2'd1;
    localparam logic [1:0] CFG_SUM_SEED   = 2'd2;

    localparam logic [7:0]  START_BYTE_RST = 8'h02;
    localparam logic [7:0]  STOP_BYTE_RST  = 8'h03;
    localparam logic [15:0] SUM_SEED_RST   = 16'h0002;

    // Result status codes
    localparam logic [1:0] ST_MATCH    = 2'd0;
    localparam logic [1:0] ST_DIFF     = 2'd1;
    localparam logic [1:0] ST_NO_START = 2'd2;

    // ASCII bounds of the hex digits
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;

    localparam logic [1:0] LAST_DIGIT = 2'd3;  // count of the fourth trailer digit

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_SUM  = 3'b010,
        PH_HEX  = 3'b100
    } fsc_phase_t;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  stop_byte;
        logic [15:0] sum_seed;
    } fsc_cfg_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] computed_sum;
        logic [15:0] received_check;
        logic        hex_bad;
    } fsc_result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] nibble;
    } fsc_hex_t;

    function automatic fsc_hex_t hex_decode(input logic [7:0] c);
        fsc_hex_t   h;
        logic [7:0] d;
        h = '{ok: 1'b0, nibble: 4'd0};
        d = 8'd0;
        if (c >= CH_0 && c <= CH_9)
        begin
            d = c - CH_0;
            h = '{ok: 1'b1, nibble: d[3:0]};
        end
        else if (c >= CH_UP_A && c <= CH_UP_F)
        begin
            d = c - CH_UP_A + 8'd10;
            h = '{ok: 1'b1, nibble: d[3:0]};
        end
        else if (c >= CH_LO_A && c <= CH_LO_F)
        begin
            d = c - CH_LO_A + 8'd10;
            h = '{ok: 1'b1, nibble: d[3:0]};
        end
        return h;
    endfunction

endpackage

`default_nettype wire

[sv/fsc_frame.sv]
// Frame tracker: phase, running sum and trailer decode for one byte per cycle while fire is high.
// Depends on fsc_pkg and frame_sum_check_macros.svh.
`default_nettype none

module fsc_frame
    import fsc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire logic [7:0]  data_byte,
    input  wire logic        frame_begin,
    input  wire fsc_cfg_t    cfg,
    output logic             res_valid,
    output fsc_result_t      res
);

    fsc_phase_t  phase_reg, phase_next;
    logic [15:0] sum_reg, sum_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        bad_reg, bad_next;
    fsc_hex_t    hx;
    logic [15:0] rx;

    always_comb
    begin
        hx         = hex_decode(data_byte);
        phase_next = phase_reg;
        sum_next   = sum_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        bad_next   = bad_reg;
        rx         = 16'd0;
        res_valid  = 1'b0;
        res        = '{status: ST_NO_START, computed_sum: 16'd0,
                       received_check: 16'd0, hex_bad: 1'b0};
        if (fire)
        begin
            if (frame_begin)
            begin
                if (data_byte != cfg.start_byte)
                begin
                    phase_next = PH_IDLE;
                    res_valid  = 1'b1;
                end
                else
                begin
                    phase_next = PH_SUM;
                    sum_next   = cfg.sum_seed;
                    acc_next   = 16'd0;
                    cnt_next   = 2'd0;
                    bad_next   = 1'b0;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        phase_next = PH_IDLE;
                    end
                    PH_SUM:
                    begin
                        sum_next = sum_reg + {8'd0, data_byte};
                        if (data_byte == cfg.stop_byte)
                        begin
                            phase_next = PH_HEX;
                            acc_next   = 16'd0;
                            cnt_next   = 2'd0;
                            bad_next   = 1'b0;
                        end
                    end
                    PH_HEX:
                    begin
                        if (hx.ok)
                            acc_next = {acc_reg[11:0], hx.nibble};
                        else
                            bad_next = 1'b1;
                        cnt_next = cnt_reg + 2'd1;
                        if (cnt_reg == LAST_DIGIT)
                        begin
                            // low byte arrives first: swap
                            rx         = bad_next ? 16'd0 : {acc_next[7:0], acc_next[15:8]};
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res.status = (sum_reg == rx) ? ST_MATCH : ST_DIFF;
                            res.computed_sum   = sum_reg;
                            res.received_check = rx;
                            res.hex_bad        = bad_next;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            sum_reg   <= 16'd0;
            acc_reg   <= 16'd0;
            cnt_reg   <= 2'd0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            bad_reg   <= bad_next;
        end
    end

`include "frame_sum_check_macros.svh"

    `FSC_ASSERT_NOW(a_res_source, res_valid, fire && (frame_begin || phase_reg == PH_HEX), "result without begin byte or trailer")
    `FSC_ASSERT_NEXT(a_bad_start_idle, fire && frame_begin && data_byte != cfg.start_byte, phase_reg == PH_IDLE, "bad start did not return to idle")

endmodule

`default_nettype wire

[sv/fsc_outbuf.sv]
// Two-entry result buffer: output register plus skid register.
// Depends on fsc_pkg and frame_sum_check_macros.svh.
`default_nettype none

module fsc_outbuf
    import fsc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        res_valid,
    input  wire fsc_result_t res,
    output logic             full,
    output logic             out_valid,
    input  wire logic        out_stall,
    output fsc_result_t      out_res
);

    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    fsc_result_t main_reg, main_next;
    fsc_result_t skid_reg, skid_next;
    logic        take;

    assign take = main_valid_reg && !out_stall;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (res_valid)
                main_next = res;
            else
                main_valid_next = 1'b0;
        end
        else if (!main_valid_reg)
        begin
            if (res_valid)
            begin
                main_next       = res;
                main_valid_next = 1'b1;
            end
        end
        else if (res_valid)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

`include "frame_sum_check_macros.svh"

    `FSC_ASSERT_NOW(a_skid_behind_main, skid_valid_reg, main_valid_reg, "skid entry without output entry")
    `FSC_ASSERT_NOW(a_no_overrun, res_valid, !skid_valid_reg, "result arrived while buffer full")

endmodule

`default_nettype wire

[sv/frame_sum_check.sv]
// Top level of the additive 16-bit frame check verifier.
// Depends on fsc_pkg, fsc_frame and fsc_outbuf.
`default_nettype none

// frame_sum_check accepts one received byte per clock cycle and checks
// framed messages: a byte marked frame_begin must equal start_byte, the
// bytes after it up to and including stop_byte are added into a 16-bit
// wrapping sum seeded with sum_seed, and the four ASCII hex characters that
// follow (low byte first) carry the expected sum. One result transaction is
// given per finished frame (match or mismatch) and per marked byte that is
// not start_byte (no-start); all other bytes produce nothing. Every byte is
// handled in the cycle it is accepted, so the sustained rate is one byte per
// cycle while in_stall is low; each result is registered from the byte that
// completes it into a two-entry buffer (output register plus skid register);
// in_stall rises only when both entries hold results that the downstream
// side has not taken. Write configuration only while no frame is in
// progress and no result is pending; stop_byte acts at once, start_byte
// and sum_seed from the next frame start. Register index 3 is ignored.
module frame_sum_check
    import fsc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input transactions
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        frame_begin,
    // result transactions
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [15:0]      computed_sum,
    output logic [15:0]      received_check,
    output logic             hex_bad,
    // configuration writes
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    fsc_cfg_t    cfg_reg;
    fsc_result_t res;
    fsc_result_t out_res;
    logic        res_valid;
    logic        buf_full;
    logic        fire;

    // Hold configuration; index past the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte <= START_BYTE_RST;
            cfg_reg.stop_byte  <= STOP_BYTE_RST;
            cfg_reg.sum_seed   <= SUM_SEED_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_BYTE: cfg_reg.start_byte <= cfg_data[7:0];
                CFG_STOP_BYTE:  cfg_reg.stop_byte  <= cfg_data[7:0];
                CFG_SUM_SEED:   cfg_reg.sum_seed   <= cfg_data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // Stall only while both buffer entries are occupied.
    assign in_stall = buf_full;
    assign fire     = in_valid && !buf_full;

    fsc_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .data_byte   (data_byte),
        .frame_begin (frame_begin),
        .cfg         (cfg_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    fsc_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign status         = out_res.status;
    assign computed_sum   = out_res.computed_sum;
    assign received_check = out_res.received_check;
    assign hex_bad        = out_res.hex_bad;

endmodule

`default_nettype wire

[verif/frame_sum_check_test.sv]
// Self-checking testbench for frame_sum_check: framed byte streams in, check results out.
// Depends on fsc_pkg (codes, ASCII bounds, result and config types) and the frame_sum_check RTL.
// Predicts each result from accepted bytes and compares it field by field with the block output.
module frame_sum_check_test;
    import fsc_pkg::*;

    localparam int       RESET_CYCLES   = 9;
    localparam int       SETTLE_CYCLES  = 4;     // extra wait after the queues drain
    localparam int       QUIET_LIMIT    = 2000;  // cycles with no transaction before giving up
    localparam int       RX_HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int       SUB_PHASES     = 6;
    localparam int       SUB_ITEMS      = 215;
    localparam logic [2:0] TRAILER_LEN  = 3'd4;
    localparam int       MAX_REPORTS    = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       mark;
    } rx_byte_t;

    typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_CHAR, FLAW_CUT} flaw_t;

    // Clock, reset and every block input start at a known value.
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic [7:0]  data_byte   = 8'h00;
    logic        frame_begin = 1'b0;
    logic        out_stall   = 1'b0;
    logic        cfg_we      = 1'b0;
    logic [1:0]  cfg_index   = CFG_START_BYTE;
    logic [15:0] cfg_data    = 16'h0000;

    logic        in_stall;
    logic        out_valid;
    logic [1:0]  status;
    logic [15:0] computed_sum;
    logic [15:0] received_check;
    logic        hex_bad;

    // Stimulus side: pending bytes and the config the generator builds frames for.
    rx_byte_t    byte_q[$];
    rx_byte_t    drv_item;
    int          bytes_queued  = 0;
    int          bytes_sent    = 0;
    logic        in_taken      = 1'b0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        rx_hold_req   = 1'b0;
    logic        rx_hold_ack   = 1'b0;
    int          rx_hold_left  = 0;
    logic [7:0]  gen_start     = START_BYTE_RST;
    logic [7:0]  gen_stop      = STOP_BYTE_RST;
    logic [15:0] gen_seed      = SUM_SEED_RST;

    // Predictor side: its own copy of the registers and the frame state.
    fsc_cfg_t    model_cfg     = '{start_byte: START_BYTE_RST, stop_byte: STOP_BYTE_RST,
                                   sum_seed: SUM_SEED_RST};
    fsc_phase_t  frame_phase   = PH_IDLE;
    logic [15:0] run_sum       = 16'h0000;
    logic [15:0] trailer_acc   = 16'h0000;
    logic [2:0]  digits_seen   = 3'd0;
    logic        trailer_bad   = 1'b0;
    fsc_result_t frame_verdicts_q[$];
    fsc_result_t got_res;
    fsc_result_t want_res;
    int          result_errors = 0;
    int          quiet_cycles  = 0;

    frame_sum_check u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .frame_begin    (frame_begin),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .computed_sum   (computed_sum),
        .received_check (received_check),
        .hex_bad        (hex_bad),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #10 clk = ~clk;

    // Decode one ASCII hex character: bit 4 flags a character that is no hex digit.
    function automatic logic [4:0] ascii_nibble(input logic [7:0] c);
        logic [7:0] off;
        off = 8'd0;
        if (c >= CH_0 && c <= CH_9)
            off = c - CH_0;
        else if (c >= CH_UP_A && c <= CH_UP_F)
            off = c - CH_UP_A + 8'd10;
        else if (c >= CH_LO_A && c <= CH_LO_F)
            off = c - CH_LO_A + 8'd10;
        else
            return 5'b1_0000;
        return {1'b0, off[3:0]};
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic lower);
        if (nib < 4'd10)
            return CH_0 + {4'h0, nib};
        return (lower ? CH_LO_A : CH_UP_A) + {4'h0, nib} - 8'd10;
    endfunction

    // Advance the predicted frame state by one accepted byte; queue the verdict it yields.
    function automatic void predict_frame_byte(input logic [7:0] b, input logic mark);
        fsc_result_t verdict;
        logic [4:0]  nib;
        logic [15:0] rx;
        if (mark)
        begin
            if (b != model_cfg.start_byte)
            begin
                // no start: report it and drop back to idle
                frame_phase = PH_IDLE;
                verdict = '{status: ST_NO_START, computed_sum: 16'h0000,
                            received_check: 16'h0000, hex_bad: 1'b0};
                frame_verdicts_q.push_back(verdict);
            end
            else
            begin
                // good start, also when a frame was under way: restart silently
                frame_phase = PH_SUM;
                run_sum     = model_cfg.sum_seed;
                trailer_acc = 16'h0000;
                digits_seen = 3'd0;
                trailer_bad = 1'b0;
            end
        end
        else if (frame_phase == PH_SUM)
        begin
            run_sum = run_sum + {8'h00, b};
            if (b == model_cfg.stop_byte)
            begin
                frame_phase = PH_HEX;
                trailer_acc = 16'h0000;
                digits_seen = 3'd0;
                trailer_bad = 1'b0;
            end
        end
        else if (frame_phase == PH_HEX)
        begin
            nib = ascii_nibble(b);
            if (nib[4])
                trailer_bad = 1'b1;
            else
                trailer_acc = {trailer_acc[11:0], nib[3:0]};
            digits_seen = digits_seen + 3'd1;
            if (digits_seen == TRAILER_LEN)
            begin
                // low byte came first on the wire: swap; a bad digit zeroes the value
                rx = trailer_bad ? 16'h0000 : {trailer_acc[7:0], trailer_acc[15:8]};
                verdict = '{status: (run_sum == rx) ? ST_MATCH : ST_DIFF,
                            computed_sum: run_sum, received_check: rx,
                            hex_bad: trailer_bad};
                frame_verdicts_q.push_back(verdict);
                frame_phase = PH_IDLE;
            end
        end
        // unmarked bytes while idle are ignored
    endfunction

    task automatic note_bad_result(input logic had_want);
        result_errors++;
        if (result_errors <= MAX_REPORTS)
        begin
            if (had_want)
                $display("mismatch: expected status=%0d sum=%h check=%h bad=%0d, got status=%0d sum=%h check=%h bad=%0d",
                         want_res.status, want_res.computed_sum, want_res.received_check,
                         want_res.hex_bad, got_res.status, got_res.computed_sum,
                         got_res.received_check, got_res.hex_bad);
            else
                $display("mismatch: unexpected result status=%0d sum=%h check=%h bad=%0d",
                         got_res.status, got_res.computed_sum, got_res.received_check,
                         got_res.hex_bad);
        end
    endtask

    // Monitor: sample at the rising edge, predict accepted bytes, check accepted results.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                got_res = '{status: status, computed_sum: computed_sum,
                            received_check: received_check, hex_bad: hex_bad};
                if (frame_verdicts_q.size() == 0)
                    note_bad_result(1'b0);
                else
                begin
                    want_res = frame_verdicts_q.pop_front();
                    if (got_res.status !== want_res.status
                        || got_res.computed_sum !== want_res.computed_sum
                        || got_res.received_check !== want_res.received_check
                        || got_res.hex_bad !== want_res.hex_bad)
                        note_bad_result(1'b1);
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_frame_byte(data_byte, frame_begin);
                bytes_sent++;
            end
            in_taken <= in_valid && !in_stall;
            // track register writes the same edge the block takes them
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_START_BYTE: model_cfg.start_byte = cfg_data[7:0];
                    CFG_STOP_BYTE:  model_cfg.stop_byte  = cfg_data[7:0];
                    CFG_SUM_SEED:   model_cfg.sum_seed   = cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // Driver: at the falling edge, hold an offered byte until taken, then offer the next
    // one or idle at random.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                drv_item = byte_q.pop_front();
                in_valid    <= 1'b1;
                data_byte   <= drv_item.data;
                frame_begin <= drv_item.mark;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, or a long hold-off counted here when requested.
    always @(negedge clk)
    begin
        if (rx_hold_req != rx_hold_ack)
        begin
            rx_hold_ack  <= rx_hold_req;
            rx_hold_left <= RX_HOLD_CYCLES;
            out_stall    <= 1'b1;
        end
        else if (rx_hold_left != 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
            out_stall    <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_item(input logic [7:0] d, input logic m);
        byte_q.push_back('{data: d, mark: m});
        bytes_queued++;
    endtask

    // Queue one frame built for the current registers, damaged as the flaw says.
    task automatic push_frame(input flaw_t flaw);
        logic [15:0] acc;
        logic [15:0] word;
        logic [15:0] mask;
        logic [7:0]  b;
        logic [4:0]  nib;
        int          len;
        int          bad_pos;
        int          i;
        // mostly short bodies, now and then a long one
        len = ($urandom_range(9) == 0) ? int'($urandom_range(40)) : int'($urandom_range(8));
        acc = gen_seed;
        push_item(gen_start, 1'b1);
        for (i = 0; i < len; i++)
        begin
            b = 8'($urandom_range(255));
            if (b == gen_stop)
                b = b + 8'd1;
            push_item(b, 1'b0);
            acc = acc + {8'h00, b};
        end
        if (flaw == FLAW_CUT)
        begin
            // stop short; whatever follows restarts or flushes the frame
            if ($urandom_range(1) == 1)
            begin
                push_item(gen_stop, 1'b0);
                repeat ($urandom_range(3))
                    push_item(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))),
                              1'b0);
            end
            return;
        end
        push_item(gen_stop, 1'b0);
        acc  = acc + {8'h00, gen_stop};
        word = {acc[7:0], acc[15:8]};
        if (flaw == FLAW_SUM)
        begin
            mask = 16'($urandom_range(65535, 1));
            word = word ^ mask;
        end
        bad_pos = (flaw == FLAW_CHAR) ? int'($urandom_range(3)) : -1;
        for (i = 3; i >= 0; i--)
        begin
            if (i == bad_pos)
            begin
                do
                begin
                    b   = 8'($urandom_range(255));
                    nib = ascii_nibble(b);
                end
                while (!nib[4]);
                push_item(b, 1'b0);
            end
            else
                push_item(hex_char(word[4*i +: 4], 1'($urandom_range(1))), 1'b0);
        end
    endtask

    // Hold until every queued byte is taken and every verdict has arrived, then settle.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (bytes_sent != bytes_queued || frame_verdicts_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] s, input logic [7:0] p,
                              input logic [15:0] seed);
        write_reg(CFG_START_BYTE, {8'h00, s});
        write_reg(CFG_STOP_BYTE, {8'h00, p});
        write_reg(CFG_SUM_SEED, seed);
        gen_start = s;
        gen_stop  = p;
        gen_seed  = seed;
    endtask

    initial
    begin : stimulus
        int sub;
        int target;
        int pick;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 33;
        recv_idle_pct = 49;

        // Directed part, reset registers: start 02, stop 03, seed 0002.
        push_item(8'h55, 1'b0);             // unmarked while idle: ignored
        push_item(8'hFF, 1'b1);             // marked byte that is not the start byte
        // clean frame with extreme body bytes: sum 0104, sent low byte first
        push_item(gen_start, 1'b1);
        push_item(8'hFF, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(gen_stop, 1'b0);
        push_item(CH_0, 1'b0);
        push_item(CH_0 + 8'd4, 1'b0);
        push_item(CH_0, 1'b0);
        push_item(CH_0 + 8'd1, 1'b0);
        // restart on a second start byte, then a wrong check word in mixed case
        push_item(gen_start, 1'b1);
        push_item(gen_start, 1'b1);
        push_item(gen_stop, 1'b0);
        push_item(CH_UP_A, 1'b0);
        push_item(CH_LO_F, 1'b0);
        push_item(CH_9, 1'b0);
        push_item(CH_UP_F, 1'b0);
        wait_drained();

        // Seed plus stop wraps to zero, so bad digits still give a match.
        set_config(8'h00, 8'hFF, 16'hFF01);
        @(posedge clk);
        push_item(8'h00, 1'b1);
        push_item(8'hFF, 1'b0);
        push_item(CH_0 - 8'd1, 1'b0);       // just below '0'
        push_item(CH_LO_A, 1'b0);
        push_item(CH_LO_A - 8'd1, 1'b0);    // just below 'a'
        push_item(CH_9 + 8'd1, 1'b0);       // just above '9'
        wait_drained();

        // Random part: well-formed frames with random content, plus damage and noise.
        for (sub = 0; sub < SUB_PHASES; sub++)
        begin
            if (sub == 0)
                set_config(8'hFF, 8'h00, 16'hFFFF);
            else if (sub == 3)
                set_config(8'h00, 8'hFF, 16'h0000);
            else
                set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                           16'($urandom_range(65535)));
            @(posedge clk);
            if (sub == 2)
            begin
                send_idle_pct = 49;
                recv_idle_pct = 33;
            end
            else if (sub == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            target = bytes_queued + SUB_ITEMS;
            while (bytes_queued < target)
            begin
                pick = int'($urandom_range(99));
                if (pick < 55)
                    push_frame(FLAW_NONE);
                else if (pick < 68)
                    push_frame(FLAW_SUM);
                else if (pick < 78)
                    push_frame(FLAW_CHAR);
                else if (pick < 90)
                    push_frame(FLAW_CUT);
                else
                    repeat ($urandom_range(6, 1))
                        push_item(8'($urandom_range(255)), $urandom_range(9) == 0);
            end
            // flush any frame left open so the registers change while idle
            push_item(gen_start ^ 8'h01, 1'b1);
            // hold the receiver off while the sender keeps offering: fill the block
            if (sub == 1 || sub == 5)
                rx_hold_req = ~rx_hold_req;
            wait_drained();
        end

        if (result_errors == 0 && frame_verdicts_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
